// ===== src/tk3m_pkg.sv =====
// Shared constants, types and helpers for the three-metric top-K tracker.
// No dependencies.
`default_nettype none
package tk3m_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int NUM_TABLES    = 3;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int MEM_DEPTH     = NUM_TABLES * TABLE_ENTRIES;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int COUNT_W       = 32;
  localparam int TAG_W         = 16;
  localparam int MEM_W         = COUNT_W + TAG_W;
  localparam int RANK_W        = 7;

  // seconds / 3600 = (seconds >> 4) / 225, the latter by reciprocal multiply;
  // ceil(2^36 / 225) is exact for any 28-bit numerator
  localparam int HOUR_PRE_SHIFT = 4;
  localparam int HOUR_N_W       = COUNT_W - HOUR_PRE_SHIFT;
  localparam int HOUR_M_W       = 29;
  localparam int HOUR_SHIFT     = 36;
  localparam int HOUR_PROD_W    = HOUR_N_W + HOUR_M_W;
  localparam logic [HOUR_M_W-1:0] HOUR_RECIP = 29'd305419897;

  localparam logic [1:0] LIST_LOGINS = 2'd0;
  localparam logic [1:0] LIST_POSTS  = 2'd1;
  localparam logic [1:0] LIST_STAY   = 2'd2;
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT_SCAN,
    ST_EMIT_PUT
  } state_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [1:0] t,
                                                 input logic [IDX_W-1:0] i);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(t) * ADDR_W'(TABLE_ENTRIES);
    return base + ADDR_W'(i);
  endfunction

endpackage
`default_nettype wire

// ===== src/top_k_three_metric_tracker_unit.sv =====
// Top level of the three-metric top-K tracker: control sequencer around one table RAM.
// Depends on tk3m_pkg, tk3m_ram and tk3m_hour_div.
//
// Usage: one request channel (in_*) and one result channel (out_*), both valid/stall.
// An offer request (command 0) carries a tag and three metrics; each of the three
// tables is scanned, one RAM read per cycle, for its first smallest count, which is
// replaced when the offered value is strictly larger. The three tables are scanned
// one after another through the single RAM read port; stay seconds are turned into
// hours by a registered reciprocal multiply alongside the first scan. An emit request
// (command 1) returns the TABLE_ENTRIES entries of one table in descending count
// order, ties in table order, last marked. Each result costs one scan of the table.
// An emit of list 3 gives no result. in_stall is high while a request is in
// progress. Results sit in an output register; a stalled receiver holds it and the
// sequencer waits. Reset empties all tables (per-entry valid bits) at once.
`default_nettype none
module top_k_three_metric_tracker_unit import tk3m_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [TAG_W-1:0]   in_user_tag,
  input  wire logic [COUNT_W-1:0] in_logins,
  input  wire logic [COUNT_W-1:0] in_posts,
  input  wire logic [COUNT_W-1:0] in_stay_seconds,
  input  wire logic [1:0]         in_which_list,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [1:0]         out_list_id,
  output logic      [RANK_W-1:0]  out_rank,
  output logic      [TAG_W-1:0]   out_ranked_tag,
  output logic      [COUNT_W-1:0] out_ranked_count,
  output logic                    out_occupied,
  output logic                    out_last
);

  state_t state_r, state_nxt;

  logic [1:0]         tbl_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TAG_W-1:0]   tag_r;
  logic [COUNT_W-1:0] logins_r, posts_r;
  logic [RANK_W-1:0]  rank_r;

  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_ent_vld_r;
  logic [COUNT_W-1:0] best_cnt_r;
  logic [TAG_W-1:0]   best_tag_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               have_r;

  logic [MEM_DEPTH-1:0]     ent_vld_r;
  logic [TABLE_ENTRIES-1:0] sent_r;

  logic               in_acc, issue, mem_we, out_free, out_load, scan_end;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [MEM_W-1:0]   rdata;
  logic [COUNT_W-1:0] d_cnt, value, hours;
  logic [TAG_W-1:0]   d_tag;
  logic               div_busy, last_rank;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign scan_end  = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign last_rank = (rank_r == RANK_W'(TABLE_ENTRIES - 1));
  assign raddr     = tbl_addr(tbl_r, cnt_r[IDX_W-1:0]);
  assign waddr     = tbl_addr(tbl_r, best_idx_r);
  // entries never written read as tag 0, count 0
  assign d_cnt     = rd_ent_vld_r ? rdata[COUNT_W-1:0] : '0;
  assign d_tag     = rd_ent_vld_r ? rdata[MEM_W-1:COUNT_W] : '0;

  always_comb begin
    unique case (tbl_r)
      LIST_LOGINS: value = logins_r;
      LIST_POSTS:  value = posts_r;
      default:     value = hours;
    endcase
  end

  tk3m_ram #(.WIDTH(MEM_W), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata ({tag_r, value}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tk3m_hour_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && (in_command == CMD_OFFER)),
    .seconds (in_stay_seconds),
    .busy    (div_busy),
    .hours   (hours)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_OFFER) begin
            state_nxt = ST_SCAN;
          end else if (in_which_list != 2'd3) begin
            state_nxt = ST_EMIT_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (tbl_r == LIST_STAY) begin
          if (!div_busy) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT_SCAN: begin
        if (scan_end) state_nxt = ST_EMIT_PUT;
      end
      ST_EMIT_PUT: begin
        if (out_free) state_nxt = last_rank ? ST_IDLE : ST_EMIT_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_SCAN, ST_EMIT_SCAN: issue = !scan_end;
      ST_DECIDE: mem_we = !(tbl_r == LIST_STAY && div_busy) && (best_cnt_r < value);
      ST_EMIT_PUT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (mem_we) ent_vld_r[waddr] <= 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= cnt_r[IDX_W-1:0];
    rd_ent_vld_r <= ent_vld_r[raddr];
    if (issue) cnt_r <= cnt_r + CNT_W'(1);

    if (in_acc) begin
      tag_r    <= in_user_tag;
      logins_r <= in_logins;
      posts_r  <= in_posts;
      tbl_r    <= (in_command == CMD_OFFER) ? LIST_LOGINS : in_which_list;
      cnt_r    <= '0;
      rank_r   <= '0;
      have_r   <= 1'b0;
      sent_r   <= '0;
    end

    if (rd_vld_r) begin
      if (state_r == ST_SCAN) begin
        // first smallest count wins
        if (rd_idx_r == '0 || d_cnt < best_cnt_r) begin
          best_cnt_r <= d_cnt;
          best_idx_r <= rd_idx_r;
        end
      end else if (!sent_r[rd_idx_r] && (!have_r || d_cnt > best_cnt_r)) begin
        // largest count not yet sent, earliest on ties
        best_cnt_r <= d_cnt;
        best_tag_r <= d_tag;
        best_idx_r <= rd_idx_r;
        have_r     <= 1'b1;
      end
    end

    if (state_r == ST_DECIDE && state_nxt == ST_SCAN) begin
      tbl_r <= tbl_r + 2'd1;
      cnt_r <= '0;
    end

    if (out_load) begin
      out_list_id      <= tbl_r;
      out_rank         <= rank_r + RANK_W'(1);
      out_ranked_tag   <= best_tag_r;
      out_ranked_count <= best_cnt_r;
      out_occupied     <= (best_cnt_r != '0);
      out_last         <= last_rank;
      sent_r[best_idx_r] <= 1'b1;
      rank_r           <= rank_r + RANK_W'(1);
      cnt_r            <= '0;
      have_r           <= 1'b0;
    end
  end

  a_no_table_three: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> tbl_r != 2'd3)
    else $error("table index out of range during a request");

  a_put_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> have_r && !sent_r[best_idx_r])
    else $error("result taken without a fresh pick");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_rank |=> state_r == ST_IDLE && out_valid && out_last)
    else $error("emit run did not finish on the last rank");

  a_write_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && tbl_r == LIST_STAY |-> !div_busy)
    else $error("stay table written before hours were ready");

endmodule
`default_nettype wire

// ===== src/tk3m_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tk3m_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/tk3m_hour_div.sv =====
// Divider by 3600 as a reciprocal multiply; numerator and result are registered.
// Depends on tk3m_pkg.
`default_nettype none
module tk3m_hour_div import tk3m_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [COUNT_W-1:0]  seconds,
  output logic                     busy,
  output logic      [COUNT_W-1:0]  hours
);

  logic [HOUR_N_W-1:0]    num_r;
  logic [COUNT_W-1:0]     hours_r;
  logic                   busy_r;
  logic [HOUR_PROD_W-1:0] prod;

  assign prod = HOUR_PROD_W'(num_r) * HOUR_PROD_W'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= seconds[COUNT_W-1:HOUR_PRE_SHIFT];
    end
    if (busy_r) begin
      hours_r <= COUNT_W'(prod[HOUR_PROD_W-1:HOUR_SHIFT]);
    end
  end

  assign busy  = busy_r;
  assign hours = hours_r;

endmodule
`default_nettype wire
